// File: hdl/olist_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Request and result types, operation and status codes, and the cell modes
// shared by the list core and its cells.
// ----------------------------------------------------------------------------
package olist_pkg;

  // Operation codes carried in a request.
  localparam logic [3:0] OP_INS_FRONT = 4'd0;
  localparam logic [3:0] OP_INS_BACK  = 4'd1;
  localparam logic [3:0] OP_INS_POS   = 4'd2;
  localparam logic [3:0] OP_INS_MATCH = 4'd3;
  localparam logic [3:0] OP_DEL_FRONT = 4'd4;
  localparam logic [3:0] OP_DEL_BACK  = 4'd5;
  localparam logic [3:0] OP_DEL_POS   = 4'd6;
  localparam logic [3:0] OP_DEL_MATCH = 4'd7;
  localparam logic [3:0] OP_SEARCH    = 4'd8;
  localparam logic [3:0] OP_REVERSE   = 4'd9;
  localparam logic [3:0] OP_LIST_ALL  = 4'd10;
  localparam logic [3:0] OP_CLEAR     = 4'd11;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // What every cell does with its element under each mode.
  typedef enum logic [1:0] {
    MODE_HOLD,  // keep the element
    MODE_INS,   // open a gap at the target and write the new value there
    MODE_DEL,   // close the gap at the target, pulling from the right
    MODE_ROT    // pull from the right below the target, front value into it
  } olist_mode_e;

  // Control shared by all cells.
  typedef struct packed {
    olist_mode_e mode;
    logic        load_hit;
  } olist_ctrl_t;

  typedef struct packed {
    logic [3:0]          operation;
    logic signed [31:0]  item_value;
    logic signed [7:0]   position;
    logic signed [31:0]  match_value;
  } olist_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [31:0]  out_value;
    logic [3:0]          found_position;
    logic [4:0]          element_count;
    logic                last;
  } olist_res_t;

endpackage

// File: hdl/ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// Ordered list engine
// Keeps an ordered list of signed values in a row of cells and serves insert,
// delete, search, reverse, list-all and clear requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every cell compares
// its element against the key in the accept cycle, and the list is updated in
// the following cycle, while busy is high; the result shows on result_o,
// flagged by result_valid_o, for one cycle right after. Reverse rotates the
// front element into place once per cycle, which keeps busy high beyond the
// update cycle, starting in the cycle that shows its result. List-all emits
// nothing in the update cycle and then streams one element per cycle while
// the row rotates: busy stays high beyond the update cycle, and the count
// results follow back to back, the final one marked by last. The receiver
// cannot stall: each result is valid for exactly one cycle.
module ordered_list_engine_core import olist_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  olist_req_t req_i,
  output logic       result_valid_o,
  output olist_res_t result_o
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_REV  = 2'd2;
  localparam logic [1:0] S_LIST = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] step_q, step_d;
  olist_req_t    req_q, req_d;
  olist_res_t    res_q, res_d;
  logic          res_valid_q, res_valid_d;

  olist_ctrl_t           ctrl;
  logic [CW-1:0]         tgt;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH-1:0] new_val;

  logic [DATA_WIDTH-1:0] cell_val   [CAPACITY];
  logic                  cell_first [CAPACITY];
  logic                  hit_chain  [CAPACITY+1];

  logic [CW-1:0]         first_idx;
  logic                  any_hit;
  logic [DATA_WIDTH-1:0] sel_val;
  logic                  full, empty;
  logic [CW-1:0]         last_idx;
  logic [CMPW-1:0]       pos_u;
  logic                  pos_low;
  logic [CW-1:0]         ins_pos, del_pos;

  // Row of cells, the first-match chain runs from the front.
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_v, next_v;
    if (i == 0) begin : g_front
      assign prev_v = '0;
    end else begin : g_mid
      assign prev_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_back
      assign next_v = cell_val[i];
    end else begin : g_inner
      assign next_v = cell_val[i+1];
    end

    olist_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW),
      .INDEX      (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .tgt_i        (tgt),
      .count_i      (count_q),
      .key_i        (key),
      .new_i        (new_val),
      .front_i      (cell_val[0]),
      .prev_i       (prev_v),
      .next_i       (next_v),
      .hit_before_i (hit_chain[i]),
      .hit_before_o (hit_chain[i+1]),
      .first_o      (cell_first[i]),
      .value_o      (cell_val[i])
    );
  end

  // Encode the first hit and pick the element at the target.
  always_comb begin
    first_idx = '0;
    sel_val   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_first[i]) begin
        first_idx = first_idx | CW'(i);
      end
      if (tgt == CW'(i)) begin
        sel_val = sel_val | cell_val[i];
      end
    end
  end

  assign any_hit  = hit_chain[CAPACITY];
  assign full     = (count_q == CW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign last_idx = count_q - CW'(1);
  assign new_val  = DATA_WIDTH'(req_q.item_value);

  // Clamp the requested position to the list ends.
  assign pos_u   = CMPW'(req_q.position[6:0]);
  assign pos_low = req_q.position[7] || (req_q.position == '0);
  assign ins_pos = pos_low ? '0 :
                   (pos_u >= CMPW'(count_q)) ? count_q : CW'(pos_u);
  assign del_pos = pos_low ? '0 :
                   (pos_u >= CMPW'(last_idx)) ? last_idx : CW'(pos_u);

  // Sequencer: accept, update, and the serial reverse and list passes.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    step_d        = step_q;
    req_d         = req_q;
    res_d         = res_q;
    res_valid_d   = 1'b0;
    ctrl.mode     = MODE_HOLD;
    ctrl.load_hit = 1'b0;
    tgt           = '0;
    key           = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d         = req_i;
          ctrl.load_hit = 1'b1;
          key = (req_i.operation == OP_INS_MATCH) ? DATA_WIDTH'(req_i.match_value)
                                                  : DATA_WIDTH'(req_i.item_value);
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_valid_d          = 1'b1;
        res_d.status         = ST_OK;
        res_d.out_value      = '0;
        res_d.found_position = '0;
        res_d.last           = 1'b1;
        state_d              = S_IDLE;
        step_d               = '0;

        unique case (req_q.operation)
          OP_INS_FRONT, OP_INS_BACK, OP_INS_POS, OP_INS_MATCH: begin
            if (full) begin
              res_d.status = ST_FULL;
            end else if ((req_q.operation == OP_INS_MATCH) && !any_hit) begin
              res_d.status = ST_NOTFOUND;
            end else begin
              ctrl.mode = MODE_INS;
              count_d   = count_q + CW'(1);
              unique case (req_q.operation)
                OP_INS_FRONT: tgt = '0;
                OP_INS_BACK:  tgt = count_q;
                OP_INS_POS:   tgt = ins_pos;
                default:      tgt = first_idx + CW'(1);
              endcase
            end
          end

          OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS, OP_DEL_MATCH: begin
            if (empty) begin
              res_d.status = ST_EMPTY;
            end else if ((req_q.operation == OP_DEL_MATCH) && !any_hit) begin
              res_d.status = ST_NOTFOUND;
            end else begin
              unique case (req_q.operation)
                OP_DEL_FRONT: tgt = '0;
                OP_DEL_BACK:  tgt = last_idx;
                OP_DEL_POS:   tgt = del_pos;
                default:      tgt = first_idx;
              endcase
              ctrl.mode       = MODE_DEL;
              count_d         = last_idx;
              res_d.out_value = 32'(sel_val);
            end
          end

          OP_SEARCH: begin
            if (empty) begin
              res_d.status = ST_EMPTY;
            end else if (!any_hit) begin
              res_d.status = ST_NOTFOUND;
            end else begin
              res_d.found_position = 4'(first_idx);
            end
          end

          OP_REVERSE: begin
            if (count_q > CW'(1)) begin
              state_d = S_REV;
            end
          end

          OP_LIST_ALL: begin
            if (empty) begin
              res_d.status = ST_EMPTY;
            end else begin
              res_valid_d = 1'b0;
              state_d     = S_LIST;
            end
          end

          OP_CLEAR: begin
            count_d = '0;
          end

          default: begin
            res_d.status = ST_OK;
          end
        endcase
        res_d.element_count = 5'(count_d);
      end

      // Move the front element to its mirrored place, one per cycle.
      S_REV: begin
        ctrl.mode = MODE_ROT;
        tgt       = last_idx - step_q;
        step_d    = step_q + CW'(1);
        if (step_q == count_q - CW'(2)) begin
          state_d = S_IDLE;
        end
      end

      // Emit the front element and rotate it to the back.
      S_LIST: begin
        ctrl.mode            = MODE_ROT;
        tgt                  = last_idx;
        res_valid_d          = 1'b1;
        res_d.status         = ST_OK;
        res_d.out_value      = 32'(cell_val[0]);
        res_d.found_position = 4'(step_q);
        res_d.element_count  = 5'(count_q);
        res_d.last           = (step_q == last_idx);
        step_d               = step_q + CW'(1);
        if (step_q == last_idx) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // A list stream that is not finished continues in the next cycle.
  a_stream_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=> result_valid_o)
    else $error("list stream broken before its last element");

  // The element count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  // A full status only comes with a full list.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status == ST_FULL) |->
      (result_o.element_count == 5'(CAPACITY)))
    else $error("full status with a list that is not full");

endmodule

// File: hdl/olist_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list element, exchanges it with its neighbors and keeps a match
// flag that feeds the first-match chain running through the row.
// ----------------------------------------------------------------------------
module olist_cell import olist_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  olist_ctrl_t           ctrl_i,
  input  logic [CW-1:0]         tgt_i,
  input  logic [CW-1:0]         count_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  input  logic [DATA_WIDTH-1:0] new_i,
  input  logic [DATA_WIDTH-1:0] front_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  input  logic                  hit_before_i,
  output logic                  hit_before_o,
  output logic                  first_o,
  output logic [DATA_WIDTH-1:0] value_o
);

  localparam logic [CW-1:0] MyIdx = CW'(INDEX);

  logic [DATA_WIDTH-1:0] value_q, value_d;
  logic                  hit_q, hit_d;

  // Element update for the current mode.
  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.mode)
      MODE_HOLD: value_d = value_q;
      MODE_INS: begin
        if (MyIdx > tgt_i) begin
          value_d = prev_i;
        end else if (MyIdx == tgt_i) begin
          value_d = new_i;
        end
      end
      MODE_DEL: begin
        if (MyIdx >= tgt_i) begin
          value_d = next_i;
        end
      end
      MODE_ROT: begin
        if (MyIdx < tgt_i) begin
          value_d = next_i;
        end else if (MyIdx == tgt_i) begin
          value_d = front_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  // Match flag, taken when a request is accepted; only held elements count.
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.load_hit) begin
      hit_d = (value_q == key_i) && (MyIdx < count_i);
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  // First-match chain: a cell is the first hit when no cell before it hit.
  assign hit_before_o = hit_before_i | hit_q;
  assign first_o      = hit_q & ~hit_before_i;
  assign value_o      = value_q;

endmodule

// File: bench/ordered_list_engine_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list engine core test
// Sends insert, delete, search, reverse, list-all, clear and unused requests
// to the list core. A shadow copy of the list works out the results of every
// accepted request. Each result strobe is checked, field by field, against
// the oldest result still awaited. A directed opening covers empty lists,
// value extremes and position clamping. Random episodes then fill, drain and
// mix the list under several rates of sender idling.
// ----------------------------------------------------------------------------
module ordered_list_engine_core_test;
  import olist_pkg::*;

  localparam int LIST_CAP      = 16;
  localparam int RANDOM_ITEMS  = 196;
  localparam int STALL_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 40;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start  = 1'b0;
  logic       busy;
  olist_req_t req_i  = '0;
  logic       result_valid_o;
  olist_res_t result_o;

  // Requests waiting to be driven, and results the list still owes.
  olist_req_t pending_reqs[$];
  olist_res_t awaited_results[$];

  // Shadow copy of the list held by the core.
  logic signed [31:0] shadow_elems [LIST_CAP];
  int                 shadow_count = 0;

  logic signed [31:0] value_pool [8];
  int idle_pct       = 0;
  int accepted_reqs  = 0;
  int checked_res    = 0;
  int mismatch_count = 0;
  int full_hits      = 0;
  int stall_cycles   = 0;

  ordered_list_engine_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Free-running clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Builds one result word; the count is the shadow count after the request.
  function automatic olist_res_t make_result(logic [1:0] st, logic signed [31:0] val,
                                             logic [3:0] fpos, logic lst);
    olist_res_t r;
    r.status         = st;
    r.out_value      = val;
    r.found_position = fpos;
    r.element_count  = shadow_count[4:0];
    r.last           = lst;
    return r;
  endfunction

  // Position of the first element equal to the value, or -1.
  function automatic int find_in_list(logic signed [31:0] v);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_elems[i] == v) return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow list and queues the results it causes.
  task automatic apply_list_request(input olist_req_t rq);
    int idx;
    int p;
    int pos;
    int i;
    logic signed [31:0] held;
    idx = 0;
    p   = 0;
    pos = $signed(rq.position);
    case (rq.operation)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS, OP_INS_MATCH: begin
        if (shadow_count >= LIST_CAP) begin
          // A full list refuses every insert before looking for a match.
          full_hits++;
          awaited_results.push_back(make_result(ST_FULL, 0, 0, 1'b1));
        end else begin
          if (rq.operation == OP_INS_FRONT) begin
            p = 0;
          end else if (rq.operation == OP_INS_BACK) begin
            p = shadow_count;
          end else if (rq.operation == OP_INS_POS) begin
            if (pos <= 0) p = 0;
            else if (pos >= shadow_count) p = shadow_count;
            else p = pos;
          end else begin
            idx = find_in_list(rq.match_value);
            p   = idx + 1;
          end
          if (rq.operation == OP_INS_MATCH && idx < 0) begin
            awaited_results.push_back(make_result(ST_NOTFOUND, 0, 0, 1'b1));
          end else begin
            for (i = shadow_count; i > p; i--) shadow_elems[i] = shadow_elems[i - 1];
            shadow_elems[p] = rq.item_value;
            shadow_count++;
            awaited_results.push_back(make_result(ST_OK, 0, 0, 1'b1));
          end
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS, OP_DEL_MATCH: begin
        if (shadow_count == 0) begin
          awaited_results.push_back(make_result(ST_EMPTY, 0, 0, 1'b1));
        end else begin
          if (rq.operation == OP_DEL_FRONT) begin
            p = 0;
          end else if (rq.operation == OP_DEL_BACK) begin
            p = shadow_count - 1;
          end else if (rq.operation == OP_DEL_POS) begin
            if (pos <= 0) p = 0;
            else if (pos >= shadow_count - 1) p = shadow_count - 1;
            else p = pos;
          end else begin
            idx = find_in_list(rq.item_value);
            p   = idx;
          end
          if (rq.operation == OP_DEL_MATCH && idx < 0) begin
            awaited_results.push_back(make_result(ST_NOTFOUND, 0, 0, 1'b1));
          end else begin
            held = shadow_elems[p];
            for (i = p; i + 1 < shadow_count; i++) shadow_elems[i] = shadow_elems[i + 1];
            shadow_count--;
            awaited_results.push_back(make_result(ST_OK, held, 0, 1'b1));
          end
        end
      end
      OP_SEARCH: begin
        if (shadow_count == 0) begin
          awaited_results.push_back(make_result(ST_EMPTY, 0, 0, 1'b1));
        end else begin
          idx = find_in_list(rq.item_value);
          if (idx < 0) awaited_results.push_back(make_result(ST_NOTFOUND, 0, 0, 1'b1));
          else awaited_results.push_back(make_result(ST_OK, 0, idx[3:0], 1'b1));
        end
      end
      OP_REVERSE: begin
        for (i = 0; i < shadow_count / 2; i++) begin
          held = shadow_elems[i];
          shadow_elems[i] = shadow_elems[shadow_count - 1 - i];
          shadow_elems[shadow_count - 1 - i] = held;
        end
        awaited_results.push_back(make_result(ST_OK, 0, 0, 1'b1));
      end
      OP_LIST_ALL: begin
        if (shadow_count == 0) begin
          awaited_results.push_back(make_result(ST_EMPTY, 0, 0, 1'b1));
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            awaited_results.push_back(make_result(ST_OK, shadow_elems[i], i[3:0],
                                                  i + 1 == shadow_count));
          end
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
        awaited_results.push_back(make_result(ST_OK, 0, 0, 1'b1));
      end
      default: begin
        // Unused codes leave the list alone and answer a plain ok.
        awaited_results.push_back(make_result(ST_OK, 0, 0, 1'b1));
      end
    endcase
  endtask

  // Driver: a request is taken at an edge where start is high and busy low.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic taken;
    logic offer;
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        apply_list_request(req_i);
        accepted_reqs++;
      end
      offer = (pending_reqs.size() != 0) && ($urandom_range(0, 99) >= idle_pct);
      if (taken || !start) begin
        if (offer) begin
          req_i <= pending_reqs.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Monitor: checks every result strobe and keeps the stall counter.
  always @(posedge clk_i) begin : monitor
    olist_res_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, result_o);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, result_o.status);
          check_field("out_value", want.out_value, result_o.out_value);
          check_field("found_position", want.found_position, result_o.found_position);
          check_field("element_count", want.element_count, result_o.element_count);
          check_field("last", want.last, result_o.last);
          checked_res++;
        end
      end
      if ((start && !busy) || result_valid_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no request or result for %0d cycles", $time, STALL_LIMIT);
    $display("ordered_list_engine_core_test: done, errors");
    $finish;
  end

  // Stimulus: directed opening, then random episodes over several idle rates.
  initial begin : stimulus
    olist_req_t rq;
    int phase_idle [4];
    int mode;
    int roll;
    phase_idle[0] = 0;
    phase_idle[1] = 46;
    phase_idle[2] = 0;
    phase_idle[3] = 16;

    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (int k = 5; k < 8; k++) value_pool[k] = $urandom;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty list answers, extremes of values and positions, unused codes.
    rq = '0;
    rq.operation = OP_LIST_ALL;  pending_reqs.push_back(rq);
    rq.operation = OP_DEL_FRONT; pending_reqs.push_back(rq);
    rq.operation = OP_DEL_BACK;  pending_reqs.push_back(rq);
    rq.operation = OP_DEL_POS;   pending_reqs.push_back(rq);
    rq.operation = OP_DEL_MATCH; pending_reqs.push_back(rq);
    rq.operation = OP_SEARCH;    pending_reqs.push_back(rq);
    rq.operation = OP_INS_MATCH; pending_reqs.push_back(rq);
    rq.operation = OP_REVERSE;   pending_reqs.push_back(rq);
    rq.operation = OP_INS_FRONT; rq.item_value = 32'sh8000_0000; pending_reqs.push_back(rq);
    rq.operation = OP_INS_BACK;  rq.item_value = 32'sh7fff_ffff; pending_reqs.push_back(rq);
    rq.operation = OP_INS_POS;   rq.item_value = 0;  rq.position = -128; pending_reqs.push_back(rq);
    rq.operation = OP_INS_POS;   rq.item_value = -1; rq.position = 127;  pending_reqs.push_back(rq);
    rq.operation = OP_INS_MATCH; rq.item_value = 5;  rq.match_value = 32'sh7fff_ffff;
    pending_reqs.push_back(rq);
    rq.operation = OP_INS_MATCH; rq.item_value = 9;  rq.match_value = 1234;
    pending_reqs.push_back(rq);
    rq.operation = OP_SEARCH;    rq.item_value = 32'sh7fff_ffff; pending_reqs.push_back(rq);
    rq.operation = OP_SEARCH;    rq.item_value = 77;  pending_reqs.push_back(rq);
    rq.operation = OP_DEL_MATCH; rq.item_value = 77;  pending_reqs.push_back(rq);
    rq.operation = OP_LIST_ALL;  pending_reqs.push_back(rq);
    rq.operation = OP_REVERSE;   pending_reqs.push_back(rq);
    rq.operation = OP_LIST_ALL;  pending_reqs.push_back(rq);
    rq.operation = OP_DEL_POS;   rq.position = -128; pending_reqs.push_back(rq);
    rq.operation = OP_DEL_POS;   rq.position = 127;  pending_reqs.push_back(rq);
    rq.operation = 4'hf;         rq.item_value = -1; rq.match_value = -1; rq.position = -1;
    pending_reqs.push_back(rq);
    rq.operation = OP_CLEAR;     pending_reqs.push_back(rq);
    rq.operation = OP_LIST_ALL;  pending_reqs.push_back(rq);

    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk_i);
      idle_pct = phase_idle[ph];
      mode = 0;
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        // Episodes: mostly inserts to reach a full list, mostly deletes, or mixed.
        if (n % 20 == 0) mode = $urandom_range(0, 2);
        roll = $urandom_range(0, 99);
        case (mode)
          0: rq.operation = (roll < 88) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(4, 11));
          1: rq.operation = (roll < 80) ? 4'($urandom_range(4, 8)) : 4'($urandom_range(0, 3));
          default: rq.operation = (roll < 8) ? 4'($urandom_range(12, 15))
                                             : 4'($urandom_range(0, 11));
        endcase
        rq.item_value  = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 7)]
                                                    : 32'($urandom);
        rq.match_value = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 7)]
                                                    : 32'($urandom);
        rq.position    = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, 17));
        pending_reqs.push_back(rq);
      end
      // Let the phase drain before the idle rate changes.
      while (pending_reqs.size() != 0 || start || awaited_results.size() != 0)
        @(negedge clk_i);
    end

    // Reverse can stay busy after its result.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      mismatch_count++;
    end
    $display("Run covered %0d requests and %0d checked results, %0d inserts refused as full.",
             accepted_reqs, checked_res, full_hits);
    $display("Mismatches found: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("ordered_list_engine_core_test: done, clean");
    end else begin
      $display("ordered_list_engine_core_test: done, errors");
    end
    $finish;
  end

endmodule
